/* design/isa_pkg.sv */
package isa_pkg;

    // array size and derived widths
    localparam int CAPACITY = 64;
    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (INDEX_W > LIVE_W) ? INDEX_W : LIVE_W;

    // read tree shape: groups of eight cells, one register level per group
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_FROM_LOWER,
        CM_FROM_UPPER
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       rd_sel;
    } t_cell_ctrl;

endpackage

/* design/isa_cell.sv */
module isa_cell
    import isa_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_value,
    input  t_word      i_lower,
    input  t_word      i_upper,
    output t_word      o_data,
    output t_word      o_rd
);

    t_word r_data;
    t_word n_data;

    // pick the next entry: hold, new word, or a neighbor's entry
    always_comb begin
        unique case (i_ctrl.mode)
            CM_HOLD:       n_data = r_data;
            CM_LOAD:       n_data = i_value;
            CM_FROM_LOWER: n_data = i_lower;
            CM_FROM_UPPER: n_data = i_upper;
            default:       n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // masked contribution to the read tree
    assign o_rd = i_ctrl.rd_sel ? r_data : '0;

endmodule

/* design/isa_read_tree.sv */
module isa_read_tree
    import isa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_words [CAPACITY],
    output t_word o_word
);

    t_word r_group [NGROUP];
    t_word n_group [NGROUP];

    // first level: or of each group of eight masked cell words
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_group[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < CAPACITY) begin
                    n_group[g] = n_group[g] | i_words[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_group <= n_group;
        end
    end

    // second level: or of the registered groups
    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGROUP; g++) begin
            o_word = o_word | r_group[g];
        end
    end

endmodule

/* design/indexed_shift_array.sv */
// Packed array of signed 32-bit entries held in a row of cells, one entry
// per cell. Append, insert, remove and overwrite update the whole row in the
// cycle the item is accepted: insert moves every entry at and above the index
// up one cell, remove moves every entry above the index down one cell. Reads
// go through a two-level registered or-tree over the masked cell outputs, so
// each result passes the group registers and then the output register. One
// item is taken every cycle while results are taken downstream. Full array
// and bad index are reported in the status and leave the array unchanged.
module indexed_shift_array
    import isa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [COUNT_W-1:0]  o_count,
    output logic [STATUS_W-1:0] o_status
);

    logic                r_s1_valid;
    logic [COUNT_W-1:0]  r_s1_count;
    logic [STATUS_W-1:0] r_s1_status;
    logic                r_out_valid;
    t_word               r_out_value;
    logic [COUNT_W-1:0]  r_out_count;
    logic [STATUS_W-1:0] r_out_status;
    logic [LIVE_W-1:0]   r_live;
    logic [LIVE_W-1:0]   n_live;

    logic                w_adv;
    logic                w_accept;
    logic [CMP_W-1:0]    w_idx;
    logic [CMP_W-1:0]    w_live;
    logic                w_full;
    logic                w_do_append;
    logic                w_do_insert;
    logic                w_do_remove;
    logic                w_do_read;
    logic                w_do_write;
    logic [STATUS_W-1:0] w_status;
    logic [CMP_W-1:0]    w_count_ext;
    t_word               w_tree;

    t_word               w_data [CAPACITY];
    t_word               w_rd   [CAPACITY];
    t_cell_ctrl          w_ctrl [CAPACITY];

    // pipeline moves unless the output holds an item that is stalled
    assign w_adv    = !(r_out_valid && i_stall);
    assign o_stall  = !w_adv;
    assign w_accept = i_valid && w_adv;

    // operation decode and checks
    assign w_idx  = CMP_W'(i_index);
    assign w_live = CMP_W'(r_live);
    assign w_full = (r_live == LIVE_W'(CAPACITY));

    always_comb begin
        w_do_append = 1'b0;
        w_do_insert = 1'b0;
        w_do_remove = 1'b0;
        w_do_read   = 1'b0;
        w_do_write  = 1'b0;
        w_status    = ST_DONE;
        unique case (i_opcode)
            OP_APPEND: begin
                if (w_full) w_status = ST_FULL;
                else        w_do_append = 1'b1;
            end
            OP_INSERT: begin
                if (w_full)               w_status = ST_FULL;
                else if (w_idx > w_live)  w_status = ST_BAD;
                else                      w_do_insert = 1'b1;
            end
            OP_REMOVE: begin
                if (w_idx >= w_live) w_status = ST_BAD;
                else                 w_do_remove = 1'b1;
            end
            OP_READ: begin
                if (w_idx >= w_live) w_status = ST_BAD;
                else                 w_do_read = 1'b1;
            end
            OP_WRITE: begin
                if (w_idx >= w_live) w_status = ST_BAD;
                else                 w_do_write = 1'b1;
            end
            default: begin
                w_status = ST_DONE;
            end
        endcase
    end

    // live count after the operation
    always_comb begin
        n_live = r_live;
        if (w_do_append || w_do_insert) begin
            n_live = r_live + LIVE_W'(1);
        end else if (w_do_remove) begin
            n_live = r_live - LIVE_W'(1);
        end
    end

    assign w_count_ext = CMP_W'(n_live);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (w_accept) begin
            r_live <= n_live;
        end
    end

    // row of entry cells with per-cell control
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [CMP_W-1:0] POS = CMP_W'(k);
        t_word w_lower;
        t_word w_upper;

        always_comb begin
            w_ctrl[k].rd_sel = w_do_read && (POS == w_idx);
            w_ctrl[k].mode   = CM_HOLD;
            if (w_accept) begin
                unique if (w_do_append && POS == w_live) begin
                    w_ctrl[k].mode = CM_LOAD;
                end else if (w_do_write && POS == w_idx) begin
                    w_ctrl[k].mode = CM_LOAD;
                end else if (w_do_insert && POS == w_idx) begin
                    w_ctrl[k].mode = CM_LOAD;
                end else if (w_do_insert && POS > w_idx) begin
                    w_ctrl[k].mode = CM_FROM_LOWER;
                end else if (w_do_remove && POS >= w_idx) begin
                    w_ctrl[k].mode = CM_FROM_UPPER;
                end else begin
                    w_ctrl[k].mode = CM_HOLD;
                end
            end
        end

        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_mid_lo
            assign w_lower = w_data[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_data[k+1];
        end

        isa_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[k]),
            .i_value (i_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[k]),
            .o_rd    (w_rd[k])
        );
    end

    // read value collection
    isa_read_tree u_tree (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_words (w_rd),
        .o_word  (w_tree)
    );

    // result pipeline: stage one beside the tree, then the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_accept;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_count   <= w_count_ext[COUNT_W-1:0];
            r_s1_status  <= w_status;
            r_out_value  <= w_tree;
            r_out_count  <= r_s1_count;
            r_out_status <= r_s1_status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_count      = r_out_count;
    assign o_status     = r_out_status;

endmodule

/* design/isa_checker.sv */
module isa_checker
    import isa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [WORD_W-1:0] o_read_value,
    input logic [COUNT_W-1:0]  o_count,
    input logic [STATUS_W-1:0] o_status
);

    // a stalled result item stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_value)
            && $stable(o_count) && $stable(o_status))
        else $error("stalled result item changed");

    // a rejected item never carries a read value
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_read_value == '0)
        else $error("rejected item carries a read value");

    // full status only when the count sits at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_count == COUNT_W'(CAPACITY))
        else $error("full status with count below capacity");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == ST_DONE || o_status == ST_FULL
            || o_status == ST_BAD)
        else $error("undefined status code");

    // input stall only while a result is waiting downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

endmodule

bind indexed_shift_array isa_checker u_isa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_read_value (o_read_value),
    .o_count      (o_count),
    .o_status     (o_status)
);

/* tb/sv/indexed_shift_array_tb.sv */
`timescale 1ns / 1ps

module indexed_shift_array_tb;
    import isa_pkg::*;

    // opcodes the block treats as no-ops
    localparam logic [OPCODE_W-1:0] OP_SPARE0 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE2 = 3'd7;

    localparam int RANDOM_ITEMS = 2000;
    localparam int BLOCK_ITEMS  = 125;
    localparam int IDLE_LIMIT   = 5000;
    localparam int TAIL_CYCLES  = 8;

    // traffic mix for a stretch of random items
    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } t_mix;

    typedef struct {
        t_word                read_value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_result;

    // shadow copy of the array plus the results it still owes
    class array_shadow;
        t_word   cells[CAPACITY];
        int      live;
        t_result owed_results[$];
        int      mismatches;
        int      results_seen;
        int      items_seen;
        int      full_rejects;
        int      bad_rejects;
        int      good_reads;
        int      peak_live;
        int      times_empty;

        function new();
            live = 0;
            mismatches = 0;
            results_seen = 0;
            items_seen = 0;
            full_rejects = 0;
            bad_rejects = 0;
            good_reads = 0;
            peak_live = 0;
            times_empty = 0;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        // apply one accepted item and queue its result
        function void note_item(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx, t_word val);
            t_result res;
            int      pos;
            int      k;
            pos = int'(idx);
            res.read_value = '0;
            res.status = ST_DONE;
            case (op)
                OP_APPEND: begin
                    if (live >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        cells[live] = val;
                        live++;
                    end
                end
                OP_INSERT: begin
                    if (live >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else if (pos > live) begin
                        res.status = ST_BAD;
                    end else begin
                        for (k = live; k > pos; k--) cells[k] = cells[k-1];
                        cells[pos] = val;
                        live++;
                    end
                end
                OP_REMOVE: begin
                    if (pos >= live) begin
                        res.status = ST_BAD;
                    end else begin
                        for (k = pos; k + 1 < live; k++) cells[k] = cells[k+1];
                        live--;
                        if (live == 0) times_empty++;
                    end
                end
                OP_READ: begin
                    if (pos >= live) begin
                        res.status = ST_BAD;
                    end else begin
                        res.read_value = cells[pos];
                        good_reads++;
                    end
                end
                OP_WRITE: begin
                    if (pos >= live) res.status = ST_BAD;
                    else cells[pos] = val;
                end
                default: ;
            endcase
            if (res.status == ST_FULL) full_rejects++;
            if (res.status == ST_BAD) bad_rejects++;
            if (live > peak_live) peak_live = live;
            res.count = live[COUNT_W-1:0];
            owed_results.push_back(res);
            items_seen++;
        endfunction

        function void flag(string what, longint exp_v, longint got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t result %0d: %s expected %0d got %0d",
                         $time, results_seen, what, exp_v, got_v);
        endfunction

        // compare one accepted result with the oldest owed one
        function void check_result(t_word rd, logic [COUNT_W-1:0] cnt,
                                   logic [STATUS_W-1:0] st);
            t_result exp_r;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result: read_value %0d count %0d status %0d",
                             $time, rd, cnt, st);
            end else begin
                exp_r = owed_results.pop_front();
                if (rd !== exp_r.read_value) flag("read_value", exp_r.read_value, rd);
                if (cnt !== exp_r.count) flag("count", exp_r.count, cnt);
                if (st !== exp_r.status) flag("status", exp_r.status, st);
            end
            results_seen++;
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [OPCODE_W-1:0] i_opcode = OP_APPEND;
    logic [INDEX_W-1:0]  i_index = '0;
    t_word               i_value = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_word               o_read_value;
    logic [COUNT_W-1:0]  o_count;
    logic [STATUS_W-1:0] o_status;

    array_shadow sb = new();
    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;

    indexed_shift_array u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    always #6 i_clk = ~i_clk;

    // receiver backpressure in bursts, off during quiet stretches
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left == 0) begin
            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    i_stall <= 1'b0;
                    stall_left <= $urandom_range(0, 5);
                end
                [55:89]: begin
                    i_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                default: begin
                    i_stall <= 1'b1;
                    stall_left <= $urandom_range(9, 39);
                end
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // result checking and progress tracking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_read_value, o_count, o_status);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // hang guard
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("indexed_shift_array regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        if (quiet) return 0;
        case ($urandom_range(0, 99)) inside
            [0:69]:  return 0;
            [70:91]: return $urandom_range(1, 3);
            default: return $urandom_range(8, 40);
        endcase
    endfunction

    function automatic t_word pick_value();
        if ($urandom_range(0, 9) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // mostly legal positions, with edges and out-of-range ones mixed in
    function automatic logic [INDEX_W-1:0] pick_index(logic [OPCODE_W-1:0] op);
        int top;
        top = (op == OP_INSERT) ? sb.live : sb.live - 1;
        case ($urandom_range(0, 99)) inside
            [0:59]:  return (top <= 0) ? '0 : INDEX_W'($urandom_range(0, top));
            [60:74]: return INDEX_W'(sb.live);
            [75:84]: return (sb.live > 0) ? INDEX_W'(sb.live - 1) : '0;
            [85:94]: return INDEX_W'($urandom_range(0, CAPACITY));
            default: return INDEX_W'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_opcode(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 95) return OPCODE_W'($urandom_range(OP_SPARE0, OP_SPARE2));
        case (mix)
            MIX_FILL: begin
                if (r < 45) return OP_APPEND;
                if (r < 70) return OP_INSERT;
                if (r < 78) return OP_REMOVE;
                if (r < 88) return OP_READ;
                return OP_WRITE;
            end
            MIX_DRAIN: begin
                if (r < 5) return OP_APPEND;
                if (r < 10) return OP_INSERT;
                if (r < 70) return OP_REMOVE;
                if (r < 85) return OP_READ;
                return OP_WRITE;
            end
            default: begin
                if (r < 18) return OP_APPEND;
                if (r < 35) return OP_INSERT;
                if (r < 70) return OP_REMOVE;
                if (r < 85) return OP_READ;
                return OP_WRITE;
            end
        endcase
    endfunction

    // present one item, hold it until taken, then idle for the gap
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx, t_word val);
        int gap;
        i_valid <= 1'b1;
        i_opcode <= op;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, idx, val);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every owed result is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_mix            mix;
        logic [OPCODE_W-1:0] op;
        int              blk;
        int              n;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty array: every indexed access is rejected
        send_item(OP_READ, 0, 0);
        send_item(OP_REMOVE, 0, 0);
        send_item(OP_WRITE, 0, 32'sd5);
        send_item(OP_INSERT, 1, 32'sd9);
        // build up with extremes; append ignores its index
        send_item(OP_INSERT, 0, 32'sh7fff_ffff);
        send_item(OP_APPEND, 127, 32'sh8000_0000);
        send_item(OP_INSERT, 2, 0);
        send_item(OP_INSERT, 1, '1);
        for (n = 0; n < 4; n++) send_item(OP_READ, INDEX_W'(n), 0);
        // one past the end and far out of range
        send_item(OP_READ, 4, 0);
        send_item(OP_READ, 127, 0);
        send_item(OP_WRITE, 3, 32'sh5a5a_5a5a);
        send_item(OP_WRITE, 64, 32'sd1);
        send_item(OP_REMOVE, 1, 0);
        send_item(OP_REMOVE, 2, 0);
        send_item(OP_REMOVE, 5, 0);
        // spare opcodes leave everything alone
        for (n = OP_SPARE0; n <= OP_SPARE2; n++) send_item(OPCODE_W'(n), 127, '1);
        send_item(OP_READ, 0, 0);
        send_item(OP_READ, 1, 0);
        wait_drained();

        // random traffic in stretches that fill, churn and drain the array
        for (blk = 0; blk * BLOCK_ITEMS < RANDOM_ITEMS; blk++) begin
            mix = t_mix'(blk % 3);
            quiet = (blk % 4 == 3);
            if (blk % 5 == 2) wait_drained();
            for (n = 0; n < BLOCK_ITEMS; n++) begin
                op = pick_opcode(mix);
                send_item(op, pick_index(op), pick_value());
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results: %0d good reads, %0d full, %0d bad index",
                 sb.items_seen, sb.results_seen, sb.good_reads, sb.full_rejects,
                 sb.bad_rejects);
        $display("array peaked at %0d entries and drained to empty %0d times, %0d mismatches",
                 sb.peak_live, sb.times_empty, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed() == 0)
            $display("indexed_shift_array regression: pass");
        else
            $display("indexed_shift_array regression: fail");
        $finish;
    end

endmodule

/* indexed_shift_array.f */
design/isa_pkg.sv
design/isa_cell.sv
design/isa_read_tree.sv
design/indexed_shift_array.sv
design/isa_checker.sv
tb/sv/indexed_shift_array_tb.sv
